[rtl/calendar_clock_counter_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// Next-cycle implication, checked out of reset.
`define CCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

[rtl/ccc_pkg.sv]
package ccc_pkg;

  // Defaults and limits
  localparam int unsigned YEAR_LIMIT_DEF = 9999;
  localparam logic [15:0] PRESCALE_RST   = 16'd1000;
  localparam int unsigned PADDR_W        = 3;

  // Register indexes
  localparam int unsigned REG_PRESCALE = 0;

  // Item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_TOGGLE = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;

  // Field tops
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd12;

  // Month lengths, February fixed at 28
  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Per-cell control from the item decode
  typedef struct packed {
    logic inc;
    logic load;
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic        second_pulse;
    logic        show_date;
    logic [3:0]  digit_one;
    logic [3:0]  digit_two;
    logic [3:0]  digit_three;
    logic [3:0]  digit_four;
  } result_t;

  function automatic logic [4:0] days_in(logic [3:0] m);
    logic [4:0] len;
    if (m == 4'd0 || m > MONTH_MAX) begin
      len = 5'd31;
    end else begin
      len = MONTH_LEN[m - 4'd1];
    end
    return len;
  endfunction

  // Tens of a value below 64: multiply by 205/2048
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd205;
    return {1'b0, p[13:11]};
  endfunction

  function automatic logic [3:0] units_of(logic [5:0] v);
    logic [5:0] r;
    r = v - {2'b00, tens_of(v)} * 6'd10;
    return r[3:0];
  endfunction

endpackage

[rtl/ccc_cell.sv]
module ccc_cell #(
  parameter int W        = 6,
  parameter int RST_VAL  = 0,
  parameter int WRAP_VAL = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccc_pkg::cell_ctrl_t ctrl_i,
  input  logic [W-1:0]        load_val_i,
  input  logic [W-1:0]        top_i,
  output logic [W-1:0]        value_o,
  output logic [W-1:0]        next_o,
  output logic                carry_o
);

  logic [W-1:0] value_q, value_d;

  // Carry to the next cell when stepping past the top
  assign carry_o = ctrl_i.inc & (value_q >= top_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = load_val_i;
    end else if (ctrl_i.inc) begin
      value_d = carry_o ? W'(WRAP_VAL) : value_q + W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= W'(RST_VAL);
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;
  assign next_o  = value_d;

endmodule

[rtl/ccc_outbuf.sv]
module ccc_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ccc_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output ccc_pkg::result_t data_o
);

  ccc_pkg::result_t slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  // Occupancy: push and pop may land in the same cycle
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/calendar_clock_counter_top.sv]
// Calendar clock counter.
// Input channel (in_valid_i/in_ready_o): one item per transfer; mode_i selects
// a base tick, a display toggle or a time load from the load_*_i fields.
// Output channel (out_valid_o/out_ready_i): exactly one result per item with
// the full time, the one-second pulse and four display digits.
// APB port: register 0 (byte address 0) is prescale, base ticks per second.
// The time is kept in a chain of counter cells (prescaler, second, minute,
// hour, day, month, year); each cell passes its carry to its neighbor within
// the cycle, so the whole chain steps together for each item taken.
// Each result is written into the result buffer when its item is taken.
// Throughput: one item per cycle while the receiver keeps up.
// A two-entry result buffer sits in front of the output: a new item is still
// taken while one result waits; with both entries full in_ready_o drops until
// the receiver takes a transfer.
// Reset: 00:00:00 on day 1, month 1, year 0, time view, prescale 1000,
// result buffer empty.
module calendar_clock_counter_top #(
  parameter int unsigned YEAR_LIMIT = ccc_pkg::YEAR_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [13:0]                 load_year_i,
  input  logic [3:0]                  load_month_i,
  input  logic [4:0]                  load_day_i,
  input  logic [4:0]                  load_hour_i,
  input  logic [5:0]                  load_minute_i,
  input  logic [5:0]                  load_second_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [5:0]                  cur_second_o,
  output logic [5:0]                  cur_minute_o,
  output logic [4:0]                  cur_hour_o,
  output logic [4:0]                  cur_day_o,
  output logic [3:0]                  cur_month_o,
  output logic [13:0]                 cur_year_o,
  output logic                        second_pulse_o,
  output logic                        show_date_o,
  output logic [3:0]                  digit_one_o,
  output logic [3:0]                  digit_two_o,
  output logic [3:0]                  digit_three_o,
  output logic [3:0]                  digit_four_o
);

  localparam logic [13:0] YEAR_TOP = 14'(YEAR_LIMIT);

  logic [15:0] prescale_q;
  logic        date_view_q, date_view_d;
  logic        accept, is_tick, is_load, prescale_sel;
  logic [15:0] tick_top;

  ccc_pkg::cell_ctrl_t ctl_tick, ctl_sec, ctl_min, ctl_hour, ctl_day, ctl_month, ctl_year;
  logic c_tick, c_sec, c_min, c_hour, c_day, c_month;

  logic [3:0]  ld_month;
  logic [4:0]  ld_day, ld_hour;
  logic [5:0]  ld_min, ld_sec;
  logic [13:0] ld_year;

  logic [5:0]  sec_d, min_d;
  logic [4:0]  hour_d, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_d;
  logic [5:0]  left, right;

  ccc_pkg::result_t res, res_out;
  logic             buf_ready;

  // APB register access
  assign pready       = 1'b1;
  assign prescale_sel = (paddr[ccc_pkg::PADDR_W-1:2] == 1'(ccc_pkg::REG_PRESCALE));
  assign prdata       = prescale_sel ? {16'h0000, prescale_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= ccc_pkg::PRESCALE_RST;
    end else if (psel && penable && pwrite && pready && prescale_sel) begin
      prescale_q <= pwdata[15:0];
    end
  end

  // Item decode
  assign in_ready_o = buf_ready;
  assign accept     = in_valid_i & in_ready_o;
  assign is_tick    = accept & (mode_i == ccc_pkg::MODE_TICK);
  assign is_load    = accept & (mode_i == ccc_pkg::MODE_LOAD);

  // Display view toggle
  assign date_view_d = date_view_q ^ (accept & (mode_i == ccc_pkg::MODE_TOGGLE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_view_q <= 1'b0;
    end else begin
      date_view_q <= date_view_d;
    end
  end

  // Load clamping
  always_comb begin
    ld_year  = (load_year_i > YEAR_TOP) ? YEAR_TOP : load_year_i;
    ld_month = (load_month_i == 4'd0) ? 4'd1 :
               (load_month_i > ccc_pkg::MONTH_MAX) ? ccc_pkg::MONTH_MAX : load_month_i;
    ld_day   = (load_day_i == 5'd0) ? 5'd1 : load_day_i;
    if (ld_day > ccc_pkg::days_in(ld_month)) begin
      ld_day = ccc_pkg::days_in(ld_month);
    end
    ld_hour  = (load_hour_i > ccc_pkg::HOUR_MAX) ? ccc_pkg::HOUR_MAX : load_hour_i;
    ld_min   = (load_minute_i > ccc_pkg::MIN_MAX) ? ccc_pkg::MIN_MAX : load_minute_i;
    ld_sec   = (load_second_i > ccc_pkg::SEC_MAX) ? ccc_pkg::SEC_MAX : load_second_i;
  end

  // Prescaler top: a zero prescale acts as one
  assign tick_top = (prescale_q == 16'd0) ? 16'd0 : prescale_q - 16'd1;

  // Carry chain controls
  assign ctl_tick  = '{inc: is_tick, load: is_load};
  assign ctl_sec   = '{inc: c_tick,  load: is_load};
  assign ctl_min   = '{inc: c_sec,   load: is_load};
  assign ctl_hour  = '{inc: c_min,   load: is_load};
  assign ctl_day   = '{inc: c_hour,  load: is_load};
  assign ctl_month = '{inc: c_day,   load: is_load};
  assign ctl_year  = '{inc: c_month, load: is_load};

  ccc_cell #(.W(16), .RST_VAL(0), .WRAP_VAL(0)) u_tick (
    .clk_i, .rst_ni, .ctrl_i(ctl_tick), .load_val_i(16'd0), .top_i(tick_top),
    .value_o(), .next_o(), .carry_o(c_tick)
  );

  ccc_cell #(.W(6), .RST_VAL(0), .WRAP_VAL(0)) u_sec (
    .clk_i, .rst_ni, .ctrl_i(ctl_sec), .load_val_i(ld_sec), .top_i(ccc_pkg::SEC_MAX),
    .value_o(), .next_o(sec_d), .carry_o(c_sec)
  );

  ccc_cell #(.W(6), .RST_VAL(0), .WRAP_VAL(0)) u_min (
    .clk_i, .rst_ni, .ctrl_i(ctl_min), .load_val_i(ld_min), .top_i(ccc_pkg::MIN_MAX),
    .value_o(), .next_o(min_d), .carry_o(c_min)
  );

  ccc_cell #(.W(5), .RST_VAL(0), .WRAP_VAL(0)) u_hour (
    .clk_i, .rst_ni, .ctrl_i(ctl_hour), .load_val_i(ld_hour), .top_i(ccc_pkg::HOUR_MAX),
    .value_o(), .next_o(hour_d), .carry_o(c_hour)
  );

  ccc_cell #(.W(5), .RST_VAL(1), .WRAP_VAL(1)) u_day (
    .clk_i, .rst_ni, .ctrl_i(ctl_day), .load_val_i(ld_day),
    .top_i(ccc_pkg::days_in(month_q)),
    .value_o(), .next_o(day_d), .carry_o(c_day)
  );

  ccc_cell #(.W(4), .RST_VAL(1), .WRAP_VAL(1)) u_month (
    .clk_i, .rst_ni, .ctrl_i(ctl_month), .load_val_i(ld_month), .top_i(ccc_pkg::MONTH_MAX),
    .value_o(month_q), .next_o(month_d), .carry_o(c_month)
  );

  // Year wraps to zero past its top; nothing follows it in the chain
  ccc_cell #(.W(14), .RST_VAL(0), .WRAP_VAL(0)) u_year (
    .clk_i, .rst_ni, .ctrl_i(ctl_year), .load_val_i(ld_year), .top_i(YEAR_TOP),
    .value_o(), .next_o(year_d), .carry_o()
  );

  // Display digits from the updated time
  assign left  = date_view_d ? {2'b00, month_d} : min_d;
  assign right = date_view_d ? {1'b0, day_d}    : sec_d;

  always_comb begin
    res.cur_second   = sec_d;
    res.cur_minute   = min_d;
    res.cur_hour     = hour_d;
    res.cur_day      = day_d;
    res.cur_month    = month_d;
    res.cur_year     = year_d;
    res.second_pulse = c_tick;
    res.show_date    = date_view_d;
    res.digit_one    = ccc_pkg::tens_of(left);
    res.digit_two    = ccc_pkg::units_of(left);
    res.digit_three  = ccc_pkg::tens_of(right);
    res.digit_four   = ccc_pkg::units_of(right);
  end

  ccc_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .push_i (accept),
    .data_i (res),
    .ready_o(buf_ready),
    .valid_o(out_valid_o),
    .pop_i  (out_valid_o & out_ready_i),
    .data_o (res_out)
  );

  assign cur_second_o   = res_out.cur_second;
  assign cur_minute_o   = res_out.cur_minute;
  assign cur_hour_o     = res_out.cur_hour;
  assign cur_day_o      = res_out.cur_day;
  assign cur_month_o    = res_out.cur_month;
  assign cur_year_o     = res_out.cur_year;
  assign second_pulse_o = res_out.second_pulse;
  assign show_date_o    = res_out.show_date;
  assign digit_one_o    = res_out.digit_one;
  assign digit_two_o    = res_out.digit_two;
  assign digit_three_o  = res_out.digit_three;
  assign digit_four_o   = res_out.digit_four;

endmodule

[rtl/ccc_chk.sv]
`include "calendar_clock_counter_top_macros.svh"

module ccc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  cur_second_o,
  input logic [5:0]  cur_minute_o,
  input logic [4:0]  cur_hour_o,
  input logic [4:0]  cur_day_o,
  input logic [3:0]  cur_month_o,
  input logic [13:0] cur_year_o,
  input logic        show_date_o,
  input logic [3:0]  digit_one_o,
  input logic [3:0]  digit_two_o,
  input logic [3:0]  digit_three_o,
  input logic [3:0]  digit_four_o
);

  // A stalled result transfer holds
  `CCC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(cur_second_o) && $stable(cur_year_o) && $stable(digit_four_o))

  // Time view digits match minute and second
  `CCC_ASSERT_IMPL(a_time_digits, clk_i, rst_ni, out_valid_o && !show_date_o,
    (digit_one_o * 10 + digit_two_o == cur_minute_o) && (digit_three_o * 10 + digit_four_o == cur_second_o))

  // Date view digits match month and day
  `CCC_ASSERT_IMPL(a_date_digits, clk_i, rst_ni, out_valid_o && show_date_o,
    (digit_one_o * 10 + digit_two_o == cur_month_o) && (digit_three_o * 10 + digit_four_o == cur_day_o))

  // Reported time stays in its legal ranges
  `CCC_ASSERT_IMPL(a_time_legal, clk_i, rst_ni, out_valid_o,
    (cur_second_o <= 6'd59) && (cur_minute_o <= 6'd59) && (cur_hour_o <= 5'd23) && (cur_day_o != 5'd0) && (cur_month_o != 4'd0) && (cur_month_o <= 4'd12))

endmodule

bind calendar_clock_counter_top ccc_chk u_ccc_chk (.*);
